@@ sv/sha_pkg.sv @@
// SHA-256 engine package: round constants, initial hash values, rotr, types.
// Used by sha_ctrl, sha_dp and sha256_hash_engine.
package sha_pkg;

   localparam int WordBits = 32;

   typedef logic [31:0] word_type;

   // one-hot controller states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_ROUND = 6'b000100,
      ST_FOLD  = 6'b001000,
      ST_PAD   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       put_byte;   // write byte at current position, bump count
      logic       put_pad;    // write 0x80 at position, zero the rest
      logic       clr_buf;    // zero the whole buffer
      logic       put_len;    // write bit length in words 14/15
      logic       load;       // copy buffer/chain into schedule/working vars
      logic       round;      // one compression round
      logic       fold;       // chain += working vars
      logic       init;       // back to initial state
      logic [5:0] rnd;        // round number
      logic [2:0] out_sel;    // digest word select
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       block_full; // current byte goes to position 63
      logic       pad_two;    // padding needs an extra block
   } sts_type;

   localparam word_type InitH [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam word_type RoundK [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
      32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
      32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
      32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
      32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
      32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WordBits - n));
   endfunction

endpackage

@@ sv/sha_dp.sv @@
// SHA-256 datapath: block buffer, byte count, schedule window, working vars, chain.
// Depends on sha_pkg; driven by sha_ctrl commands.
module sha_dp
   import sha_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [7:0] in_byte,
   output sts_type    sts,
   output word_type   digest_word
);

   word_type   buf_ff [16];
   word_type   buf_in [16];
   word_type   win_ff [16];
   word_type   var_ff [8];
   word_type   chain_ff [8];
   logic [63:0] cnt_ff;

   logic [5:0] pos;
   logic [3:0] pos_w;
   logic [1:0] pos_b;

   assign pos   = cnt_ff[5:0];
   assign pos_w = pos[5:2];
   assign pos_b = pos[1:0];

   assign sts.block_full = (pos == 6'h3F);
   assign sts.pad_two    = (pos >= 6'd56);
   assign digest_word    = chain_ff[cmd.out_sel];

   // buffer update
   always_comb begin
      buf_in = buf_ff;
      if (cmd.put_byte) begin
         buf_in[pos_w][(3 - pos_b) * 8 +: 8] = in_byte;
      end
      if (cmd.put_pad) begin
         for (int i = 0; i < 16; i++) begin
            for (int b = 0; b < 4; b++) begin
               if ({i[3:0], b[1:0]} == pos) begin
                  buf_in[i][(3 - b) * 8 +: 8] = 8'h80;
               end else if ({i[3:0], b[1:0]} > pos) begin
                  buf_in[i][(3 - b) * 8 +: 8] = 8'h00;
               end
            end
         end
      end
      if (cmd.clr_buf) begin
         for (int i = 0; i < 16; i++) buf_in[i] = '0;
      end
      if (cmd.put_len) begin
         buf_in[14] = cnt_ff[60:29];
         buf_in[15] = {cnt_ff[28:0], 3'b000};
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   // round logic
   word_type w2, w15, s0, s1, w_new, w_use, t1, t2;
   logic [3:0] r4;
   assign r4    = cmd.rnd[3:0];
   assign w2    = win_ff[4'(r4 - 4'd2)];
   assign w15   = win_ff[4'(r4 - 4'd15)];
   assign s1    = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
   assign s0    = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
   assign w_new = s1 + win_ff[4'(r4 - 4'd7)] + s0 + win_ff[r4];
   assign w_use = (cmd.rnd < 6'd16) ? win_ff[r4] : w_new;
   assign t1 = var_ff[7] + (rotr(var_ff[4], 6) ^ rotr(var_ff[4], 11) ^ rotr(var_ff[4], 25))
             + (var_ff[6] ^ (var_ff[4] & (var_ff[5] ^ var_ff[6]))) + RoundK[cmd.rnd] + w_use;
   assign t2 = (rotr(var_ff[0], 2) ^ rotr(var_ff[0], 13) ^ rotr(var_ff[0], 22))
             + ((var_ff[0] & var_ff[1]) | (var_ff[2] & (var_ff[0] | var_ff[1])));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         win_ff <= buf_ff;
         var_ff <= chain_ff;
      end else if (cmd.round) begin
         win_ff[r4] <= w_use;
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         chain_ff <= InitH;
         cnt_ff   <= '0;
      end else begin
         if (cmd.fold) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + var_ff[i];
         end
         if (cmd.put_byte) cnt_ff <= cnt_ff + 64'd1;
      end
   end

endmodule

@@ sv/sha_ctrl.sv @@
// SHA-256 controller: sequences byte intake, compression rounds, padding, digest output.
// Depends on sha_pkg; commands sha_dp.
module sha_ctrl
   import sha_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  logic    in_present,
   input  logic    in_last,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output logic [2:0] out_index,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [2:0] idx_ff, idx_in;
   logic       fin_ff, fin_in;   // message is ending
   logic       two_ff, two_in;   // extra padding block pending

   logic acc;
   assign in_ready  = (state_ff == ST_IDLE);
   assign acc       = in_valid && in_ready;
   assign out_valid = (state_ff == ST_EMIT);
   assign out_index = idx_ff;

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      fin_in   = fin_ff;
      two_in   = two_ff;
      cmd      = '0;
      cmd.rnd  = rnd_ff;
      cmd.out_sel = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd.put_byte = in_present;
               fin_in = in_last;
               if (in_present && sts.block_full) state_in = ST_LOAD;
               else if (in_last) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            // buffer ready for pad write; count is final here
            cmd.put_pad = 1'b1;
            two_in = sts.pad_two;
            if (!sts.pad_two) cmd.put_len = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (two_ff) begin
               cmd.clr_buf = 1'b1;
               cmd.put_len = 1'b1;
               two_in   = 1'b0;
               state_in = ST_LOAD;
            end else if (fin_ff) begin
               // fin set with no pad done yet means a full block just ended
               state_in = ST_EMIT;
               idx_in   = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.init = 1'b1;
                  fin_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // padded flag separates "full block then pad" from "final block done"
   logic pad_ff, pad_in;
   always_comb begin
      pad_in = pad_ff;
      if (state_ff == ST_PAD) pad_in = 1'b1;
      if (state_ff == ST_IDLE) pad_in = 1'b0;
   end

   state_type state_sel;
   always_comb begin
      state_sel = state_in;
      if (state_ff == ST_FOLD && !two_ff && fin_ff && !pad_ff) state_sel = ST_PAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         fin_ff   <= 1'b0;
         two_ff   <= 1'b0;
         pad_ff   <= 1'b0;
      end else begin
         state_ff <= state_sel;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         fin_ff   <= fin_in;
         two_ff   <= two_in;
         pad_ff   <= pad_in;
      end
   end

endmodule

@@ sv/sha256_hash_engine.sv @@
// SHA-256 hash engine top level: joins sha_ctrl and sha_dp.
// Depends on sha_pkg, sha_ctrl, sha_dp.
//
// Usage: message bytes enter on the req_ stream, one transaction per byte.
// req_tdata[7:0] is the byte, req_tuser marks it present (0 lets an empty
// message finish), req_tlast ends the message.
// A byte that does not fill a block leaves the engine ready for the next one.
// A byte that completes a 64-byte block starts the load, 64 rounds of the single
// shared round unit and the fold into the chaining words. An end transaction
// adds padding: one final block, or two when the length spills over.
// The digest then appears on rsp_ as eight transactions, word 0 (most
// significant) first, rsp_tlast on word 7. Input is held off (req_tready low)
// from the end transaction until the last word is taken; a stalled receiver
// simply holds the current word. After word 7 the engine re-initializes.
// Reset (synchronous, active high) restores the initial hash values and a
// zero byte count; no clearing pass is needed.
module sha256_hash_engine
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
   output logic        rsp_tlast    // last_word
);

   cmd_type    cmd;
   sts_type    sts;
   word_type   dword;
   logic [2:0] idx;

   sha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_present (req_tuser),
      .in_last    (req_tlast),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_index  (idx),
      .sts        (sts),
      .cmd        (cmd)
   );

   sha_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_byte     (req_tdata),
      .sts         (sts),
      .digest_word (dword)
   );

   assign rsp_tdata = {5'b0, idx, dword};
   assign rsp_tlast = (idx == 3'd7);

   a_no_accept_during_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input accepted during digest output");

   a_word_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tdata[34:32] ==
      $past(rsp_tdata[34:32]) + 3'd1)) else $error("digest index skipped");

   a_done_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready) else $error("no return to idle");

endmodule
